@@ hw/rtl/sorted_key_table_assert.svh @@
// Assertion macros shared by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");

`endif

@@ hw/rtl/skt_pkg.sv @@
// Package with the types, codes and default sizes of the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int CAPACITY_DEF     = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Port field types at their fixed widths.
    typedef logic [2:0]  t_act_field;
    typedef logic [31:0] t_word;
    typedef logic [5:0]  t_pos;
    typedef logic [6:0]  t_cnt;

    // Operation codes carried by the action field.
    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_DELETE    = 3'd2,
        ACT_SEARCH    = 3'd3,
        ACT_RESET_CUR = 3'd4,
        ACT_NEXT      = 3'd5
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_END       = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_PUT,
        S_DEL_CHK,
        S_DEL_SH,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_NXT_RD,
        S_FIN
    } t_state;

    // Outcome of the shared key comparator.
    typedef struct packed {
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

`default_nettype wire

@@ hw/rtl/skt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]     i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/skt_cmp.sv @@
// Shared key comparator used by the scan, shift and binary search steps.
`timescale 1ns / 1ps
`default_nettype none

module skt_cmp #(
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  wire logic [KEY_BITS-1:0] i_stored_key,
    input  wire logic [KEY_BITS-1:0] i_query_key,
    output skt_pkg::t_cmp_res        o_res
);

    // Equality and greater-than of the stored key against the query key.
    always_comb begin
        o_res.eq = (i_stored_key == i_query_key);
        o_res.gt = (i_stored_key > i_query_key);
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_key_table.sv @@
// Top level of the sorted key table: sequencer, entry memory and result register.
//
//   channel | direction | handshake                | fields
//   --------+-----------+--------------------------+------------------------------------
//   in      | to block  | i_in_valid / o_in_stall  | action, key, payload
//   out     | from block| o_out_valid / i_out_stall| status, position, key_out,
//           |           |                          | payload_out, count
//
// Clear, reset cursor and unused codes go straight to the finish state; next item first reads
// the entry at the cursor when one is left. Insert moves each larger entry up one place, one
// entry moved per cycle, then places the record; an empty table goes straight to placing.
// A full table goes to finish. Delete runs a forward scan, then one move per cycle.
// Search reads and then checks one probe at a time, over at most log2(count)+1 probes,
// until a hit or an empty range ends it.
// This stepping is set by the single memory read port and the shared comparator.
// Reset is synchronous and active low; the memory needs no clearing pass.
// While a word waits on a stalled output, the next word is accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_assert.svh"

module sorted_key_table #(
    parameter int CAPACITY     = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = skt_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire skt_pkg::t_act_field i_action,
    input  wire skt_pkg::t_word      i_key,
    input  wire skt_pkg::t_word      i_payload,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output skt_pkg::t_status         o_status,
    output skt_pkg::t_pos            o_position,
    output skt_pkg::t_word           o_key_out,
    output skt_pkg::t_word           o_payload_out,
    output skt_pkg::t_cnt            o_count
);

    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int ENT_BITS  = KEY_BITS + PAYLOAD_BITS;

    // Control state.
    skt_pkg::t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [CNT_BITS-1:0] r_cursor, n_cursor;
    logic r_out_vld, n_out_vld;

    // Working registers of the current word.
    logic [CNT_BITS-1:0]     r_idx, n_idx;
    logic [CNT_BITS-1:0]     r_lo, n_lo;
    logic [CNT_BITS-1:0]     r_hi, n_hi;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;

    // Finished result waiting for the output register.
    skt_pkg::t_status        r_st_status, n_st_status;
    logic [ADDR_BITS-1:0]    r_st_pos, n_st_pos;
    logic [KEY_BITS-1:0]     r_st_key, n_st_key;
    logic [PAYLOAD_BITS-1:0] r_st_pay, n_st_pay;

    // Output register.
    skt_pkg::t_status r_status, n_status;
    skt_pkg::t_pos    r_position, n_position;
    skt_pkg::t_word   r_key_out, n_key_out;
    skt_pkg::t_word   r_payload_out, n_payload_out;
    skt_pkg::t_cnt    r_count_out, n_count_out;

    // Memory port signals.
    logic                 w_wr_en;
    logic [ADDR_BITS-1:0] w_wr_addr;
    logic [ENT_BITS-1:0]  w_wr_data;
    logic                 w_rd_en;
    logic [ADDR_BITS-1:0] w_rd_addr;
    logic [ENT_BITS-1:0]  w_rd_data;
    logic [KEY_BITS-1:0]     w_rd_key;
    logic [PAYLOAD_BITS-1:0] w_rd_pay;

    skt_pkg::t_cmp_res w_cmp;
    skt_pkg::t_action  w_act;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic [CNT_BITS:0] w_cnt_ext;
    logic [CNT_BITS:0] w_idx_p1;
    logic [CNT_BITS:0] w_idx_p2;
    logic [CNT_BITS:0] w_mid_sum;
    logic [CNT_BITS-1:0] w_mid;
    logic [CNT_BITS-1:0] w_idx_m2;

    // Entry memory, key in the upper bits and payload in the lower bits.
    skt_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared comparator: the entry just read against the word's key.
    skt_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_stored_key (w_rd_key),
        .i_query_key  (r_key),
        .o_res        (w_cmp)
    );

    // Handshake and index arithmetic.
    always_comb begin
        w_rd_key   = w_rd_data[ENT_BITS-1:PAYLOAD_BITS];
        w_rd_pay   = w_rd_data[PAYLOAD_BITS-1:0];
        w_act      = skt_pkg::t_action'(i_action);
        o_in_stall = (r_state != skt_pkg::S_IDLE);
        w_in_acc   = i_in_valid && !o_in_stall;
        w_out_free = !r_out_vld || !i_out_stall;
        w_full     = (r_count == CNT_BITS'(CAPACITY));
        w_cnt_ext  = {1'b0, r_count};
        w_idx_p1   = {1'b0, r_idx} + (CNT_BITS + 1)'(1);
        w_idx_p2   = {1'b0, r_idx} + (CNT_BITS + 1)'(2);
        w_idx_m2   = r_idx - CNT_BITS'(2);
        w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (CNT_BITS + 1)'(1);
        w_mid      = w_mid_sum[CNT_BITS:1];
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    case (w_act)
                        skt_pkg::ACT_INSERT: begin
                            if (w_full) begin
                                n_state = skt_pkg::S_FIN;
                            end else if (r_count == '0) begin
                                n_state = skt_pkg::S_INS_PUT;
                            end else begin
                                n_state = skt_pkg::S_INS_CHK;
                            end
                        end
                        skt_pkg::ACT_DELETE: begin
                            n_state = (r_count == '0) ? skt_pkg::S_FIN : skt_pkg::S_DEL_CHK;
                        end
                        skt_pkg::ACT_SEARCH: begin
                            n_state = skt_pkg::S_SRCH_RD;
                        end
                        skt_pkg::ACT_NEXT: begin
                            n_state = (r_cursor < r_count) ? skt_pkg::S_NXT_RD
                                                           : skt_pkg::S_FIN;
                        end
                        default: begin
                            n_state = skt_pkg::S_FIN;
                        end
                    endcase
                end
            end
            skt_pkg::S_INS_CHK: begin
                if (!w_cmp.gt || (r_idx == CNT_BITS'(1))) begin
                    n_state = skt_pkg::S_INS_PUT;
                end
            end
            skt_pkg::S_INS_PUT: begin
                n_state = skt_pkg::S_FIN;
            end
            skt_pkg::S_DEL_CHK: begin
                if (w_idx_p1 < w_cnt_ext) begin
                    n_state = w_cmp.eq ? skt_pkg::S_DEL_SH : skt_pkg::S_DEL_CHK;
                end else begin
                    n_state = skt_pkg::S_FIN;
                end
            end
            skt_pkg::S_DEL_SH: begin
                if (!(w_idx_p2 < w_cnt_ext)) begin
                    n_state = skt_pkg::S_FIN;
                end
            end
            skt_pkg::S_SRCH_RD: begin
                n_state = (r_lo < r_hi) ? skt_pkg::S_SRCH_CHK : skt_pkg::S_FIN;
            end
            skt_pkg::S_SRCH_CHK: begin
                n_state = w_cmp.eq ? skt_pkg::S_FIN : skt_pkg::S_SRCH_RD;
            end
            skt_pkg::S_NXT_RD: begin
                n_state = skt_pkg::S_FIN;
            end
            skt_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = skt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skt_pkg::S_IDLE;
            end
        endcase
    end

    // Memory port control for each state.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[ADDR_BITS-1:0];
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        case (r_state)
            skt_pkg::S_IDLE: begin
                w_rd_en = w_in_acc;
                case (w_act)
                    skt_pkg::ACT_INSERT: w_rd_addr = ADDR_BITS'(r_count - CNT_BITS'(1));
                    skt_pkg::ACT_NEXT:   w_rd_addr = r_cursor[ADDR_BITS-1:0];
                    default:             w_rd_addr = '0;
                endcase
            end
            skt_pkg::S_INS_CHK: begin
                // Move the entry up one place if it is larger, and fetch the one below it.
                w_wr_en   = w_cmp.gt;
                w_rd_en   = 1'b1;
                w_rd_addr = w_idx_m2[ADDR_BITS-1:0];
            end
            skt_pkg::S_INS_PUT: begin
                w_wr_en   = 1'b1;
                w_wr_data = {r_key, r_pay};
            end
            skt_pkg::S_DEL_CHK: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_idx_p1[ADDR_BITS-1:0];
            end
            skt_pkg::S_DEL_SH: begin
                // Move the entry down one place and fetch the next one.
                w_wr_en   = 1'b1;
                w_rd_en   = 1'b1;
                w_rd_addr = w_idx_p2[ADDR_BITS-1:0];
            end
            skt_pkg::S_SRCH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_mid[ADDR_BITS-1:0];
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // Datapath and result registers.
    always_comb begin
        n_count       = r_count;
        n_cursor      = r_cursor;
        n_idx         = r_idx;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_key         = r_key;
        n_pay         = r_pay;
        n_st_status   = r_st_status;
        n_st_pos      = r_st_pos;
        n_st_key      = r_st_key;
        n_st_pay      = r_st_pay;
        n_out_vld     = r_out_vld && i_out_stall;
        n_status      = r_status;
        n_position    = r_position;
        n_key_out     = r_key_out;
        n_payload_out = r_payload_out;
        n_count_out   = r_count_out;
        case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_key       = KEY_BITS'(i_key);
                    n_pay       = PAYLOAD_BITS'(i_payload);
                    n_st_status = skt_pkg::STS_OK;
                    n_st_pos    = '0;
                    n_st_key    = '0;
                    n_st_pay    = '0;
                    case (w_act)
                        skt_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        skt_pkg::ACT_INSERT: begin
                            n_idx = r_count;
                            if (w_full) begin
                                n_st_status = skt_pkg::STS_FULL;
                            end
                        end
                        skt_pkg::ACT_DELETE: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_st_status = skt_pkg::STS_NOT_FOUND;
                            end
                        end
                        skt_pkg::ACT_SEARCH: begin
                            n_lo = '0;
                            n_hi = r_count;
                        end
                        skt_pkg::ACT_RESET_CUR: begin
                            n_cursor = '0;
                        end
                        skt_pkg::ACT_NEXT: begin
                            if (r_cursor < r_count) begin
                                n_idx    = r_cursor;
                                n_cursor = r_cursor + CNT_BITS'(1);
                            end else begin
                                n_st_status = skt_pkg::STS_END;
                            end
                        end
                        default: begin
                            n_st_status = skt_pkg::STS_OK;
                        end
                    endcase
                end
            end
            skt_pkg::S_INS_CHK: begin
                if (w_cmp.gt) begin
                    n_idx = r_idx - CNT_BITS'(1);
                end
            end
            skt_pkg::S_INS_PUT: begin
                n_count  = r_count + CNT_BITS'(1);
                n_st_pos = r_idx[ADDR_BITS-1:0];
                n_st_key = r_key;
                n_st_pay = r_pay;
            end
            skt_pkg::S_DEL_CHK: begin
                if (w_cmp.eq) begin
                    n_st_pos = r_idx[ADDR_BITS-1:0];
                    n_st_key = w_rd_key;
                    n_st_pay = w_rd_pay;
                    if (!(w_idx_p1 < w_cnt_ext)) begin
                        n_count = r_count - CNT_BITS'(1);
                    end
                end else begin
                    n_idx = w_idx_p1[CNT_BITS-1:0];
                    if (!(w_idx_p1 < w_cnt_ext)) begin
                        n_st_status = skt_pkg::STS_NOT_FOUND;
                    end
                end
            end
            skt_pkg::S_DEL_SH: begin
                n_idx = w_idx_p1[CNT_BITS-1:0];
                if (!(w_idx_p2 < w_cnt_ext)) begin
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            skt_pkg::S_SRCH_RD: begin
                n_idx = w_mid;
                if (!(r_lo < r_hi)) begin
                    n_st_status = skt_pkg::STS_NOT_FOUND;
                end
            end
            skt_pkg::S_SRCH_CHK: begin
                // Narrow the half-open range [lo, hi) around the probed entry.
                if (w_cmp.eq) begin
                    n_st_pos = r_idx[ADDR_BITS-1:0];
                    n_st_key = w_rd_key;
                    n_st_pay = w_rd_pay;
                end else if (w_cmp.gt) begin
                    n_hi = r_idx;
                end else begin
                    n_lo = w_idx_p1[CNT_BITS-1:0];
                end
            end
            skt_pkg::S_NXT_RD: begin
                n_st_pos = r_idx[ADDR_BITS-1:0];
                n_st_key = w_rd_key;
                n_st_pay = w_rd_pay;
            end
            skt_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out_vld     = 1'b1;
                    n_status      = r_st_status;
                    n_position    = skt_pkg::t_pos'(r_st_pos);
                    n_key_out     = skt_pkg::t_word'(r_st_key);
                    n_payload_out = skt_pkg::t_word'(r_st_pay);
                    n_count_out   = skt_pkg::t_cnt'(r_count);
                end
            end
            default: begin
                n_out_vld = r_out_vld && i_out_stall;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skt_pkg::S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_out_vld <= n_out_vld;
        end
    end

    // Data registers without reset.
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_key         <= n_key;
        r_pay         <= n_pay;
        r_st_status   <= n_st_status;
        r_st_pos      <= n_st_pos;
        r_st_key      <= n_st_key;
        r_st_pay      <= n_st_pay;
        r_status      <= n_status;
        r_position    <= n_position;
        r_key_out     <= n_key_out;
        r_payload_out <= n_payload_out;
        r_count_out   <= n_count_out;
    end

    // Output ports.
    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_payload_out;
    assign o_count       = r_count_out;

    // The entry count never passes the capacity.
    `SKT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(CAPACITY))
    // A finished result is held while the output register is still occupied.
    `SKT_ASSERT_NXT(a_fin_holds, i_clk, i_rst_n,
        (r_state == skt_pkg::S_FIN) && !w_out_free, r_state == skt_pkg::S_FIN)
    // Placing the new record adds exactly one entry.
    `SKT_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n,
        r_state == skt_pkg::S_INS_PUT, r_count == $past(r_count) + CNT_BITS'(1))
    // The memory is written only while moving or placing entries.
    `SKT_ASSERT_IMP(a_write_state, i_clk, i_rst_n, w_wr_en,
        (r_state == skt_pkg::S_INS_CHK) || (r_state == skt_pkg::S_INS_PUT)
        || (r_state == skt_pkg::S_DEL_SH))

endmodule

`default_nettype wire
